// ===== src/hcs_pkg.sv =====
// Shared types and constants of the heater and cutter sequencer.
package hcs_pkg;

  localparam int TempWidth  = 13;
  localparam int LevelWidth = 12;
  localparam int BandWidth  = 10;
  localparam int TickWidth  = 10;
  localparam int ModeWidth  = 3;
  localparam int CfgIdxWidth = 3;

  localparam logic [CfgIdxWidth-1:0] CFG_TARGET_TEMP      = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_HYSTERESIS_BAND  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_MAX_SAFE_TEMP    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_RESUME_TEMP      = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_FEED_SPEED_SET   = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CFG_CUTTER_SPEED_SET = 3'd5;
  localparam logic [CfgIdxWidth-1:0] CFG_PAUSE_TICKS      = 3'd6;
  localparam logic [CfgIdxWidth-1:0] CFG_CUT_PHASE_TICKS  = 3'd7;

  typedef struct packed {
    logic signed [TempWidth-1:0] temperature;
    logic                        start_pressed;
    logic                        beam_blocked;
  } in_t;

  typedef struct packed {
    logic [ModeWidth-1:0]  mode_code;
    logic                  heater_on;
    logic                  feed_run;
    logic [LevelWidth-1:0] feed_speed;
    logic                  cutter_run;
    logic                  cutter_reverse;
    logic [LevelWidth-1:0] cutter_speed;
  } out_t;

  typedef struct packed {
    logic [LevelWidth-1:0] target_temp;
    logic [BandWidth-1:0]  hysteresis_band;
    logic [LevelWidth-1:0] max_safe_temp;
    logic [LevelWidth-1:0] resume_temp;
    logic [LevelWidth-1:0] feed_speed_set;
    logic [LevelWidth-1:0] cutter_speed_set;
    logic [TickWidth-1:0]  pause_ticks;
    logic [TickWidth-1:0]  cut_phase_ticks;
  } cfg_t;

endpackage

// ===== src/hcs_cfg_regs.sv =====
// Configuration register file of the heater and cutter sequencer.
module hcs_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_en_i,
  input  logic [hcs_pkg::CfgIdxWidth-1:0]    wr_index_i,
  input  logic [hcs_pkg::LevelWidth-1:0]     wr_data_i,
  output hcs_pkg::cfg_t                      cfg_o
);
  import hcs_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_temp      <= 12'd1800;
      cfg_q.hysteresis_band  <= 10'd50;
      cfg_q.max_safe_temp    <= 12'd2200;
      cfg_q.resume_temp      <= 12'd1000;
      cfg_q.feed_speed_set   <= 12'd1000;
      cfg_q.cutter_speed_set <= 12'd800;
      cfg_q.pause_ticks      <= 10'd5;
      cfg_q.cut_phase_ticks  <= 10'd10;
    end else if (wr_en_i) begin
      case (wr_index_i)
        CFG_TARGET_TEMP:      cfg_q.target_temp      <= wr_data_i;
        CFG_HYSTERESIS_BAND:  cfg_q.hysteresis_band  <= wr_data_i[BandWidth-1:0];
        CFG_MAX_SAFE_TEMP:    cfg_q.max_safe_temp    <= wr_data_i;
        CFG_RESUME_TEMP:      cfg_q.resume_temp      <= wr_data_i;
        CFG_FEED_SPEED_SET:   cfg_q.feed_speed_set   <= wr_data_i;
        CFG_CUTTER_SPEED_SET: cfg_q.cutter_speed_set <= wr_data_i;
        CFG_PAUSE_TICKS:      cfg_q.pause_ticks      <= wr_data_i[TickWidth-1:0];
        CFG_CUT_PHASE_TICKS:  cfg_q.cut_phase_ticks  <= wr_data_i[TickWidth-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/hcs_ctrl.sv =====
// Mode state machine and drive state of the sequencer, advanced once per item.
module hcs_ctrl #(
  parameter int COUNT_WIDTH = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  hcs_pkg::in_t  item_i,
  input  hcs_pkg::cfg_t cfg_i,
  output hcs_pkg::out_t res_o
);
  import hcs_pkg::*;

  localparam int LimWidth = (COUNT_WIDTH > TickWidth) ? COUNT_WIDTH : TickWidth;
  localparam int CmpWidth = TempWidth + 1;

  typedef enum logic [ModeWidth-1:0] {
    MODE_HEATING  = 3'd0,
    MODE_READY    = 3'd1,
    MODE_ROLLING  = 3'd2,
    MODE_PAUSE    = 3'd3,
    MODE_CUTTING  = 3'd4,
    MODE_OVERHEAT = 3'd5
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic                   heater_q, heater_d;
  logic                   feed_q, feed_d;
  logic                   cut_en_q, cut_en_d;
  logic                   dir_q, dir_d;
  logic                   upstroke_q, upstroke_d;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;

  logic signed [CmpWidth-1:0] temp_s, tgt_s, low_s, max_s, resume_s;
  logic                       hot;
  logic [COUNT_WIDTH-1:0]     tick_inc;
  logic [LimWidth-1:0]        tick_inc_ext, count_max_ext;
  logic [LimWidth-1:0]        pause_lim, cut_lim, pause_ext, cut_ext;

  always_comb begin
    temp_s   = CmpWidth'(item_i.temperature);
    tgt_s    = $signed({2'b00, cfg_i.target_temp});
    low_s    = tgt_s - $signed({4'b0000, cfg_i.hysteresis_band});
    max_s    = $signed({2'b00, cfg_i.max_safe_temp});
    resume_s = $signed({2'b00, cfg_i.resume_temp});
    hot      = temp_s >= max_s;

    tick_inc      = (tick_q == {COUNT_WIDTH{1'b1}}) ? tick_q : tick_q + COUNT_WIDTH'(1);
    tick_inc_ext  = LimWidth'(tick_inc);
    count_max_ext = LimWidth'({COUNT_WIDTH{1'b1}});
    pause_ext     = LimWidth'(cfg_i.pause_ticks);
    cut_ext       = LimWidth'(cfg_i.cut_phase_ticks);

    if (pause_ext == '0) begin
      pause_lim = LimWidth'(1);
    end else if (pause_ext > count_max_ext) begin
      pause_lim = count_max_ext;
    end else begin
      pause_lim = pause_ext;
    end
    if (cut_ext == '0) begin
      cut_lim = LimWidth'(1);
    end else if (cut_ext > count_max_ext) begin
      cut_lim = count_max_ext;
    end else begin
      cut_lim = cut_ext;
    end
  end

  always_comb begin
    mode_d     = mode_q;
    heater_d   = heater_q;
    feed_d     = feed_q;
    cut_en_d   = cut_en_q;
    dir_d      = dir_q;
    upstroke_d = upstroke_q;
    tick_d     = tick_q;
    case (mode_q)
      MODE_READY: begin
        if (temp_s < low_s) begin
          heater_d = 1'b1;
        end else if (temp_s > tgt_s) begin
          heater_d = 1'b0;
        end
        if (hot) begin
          mode_d = MODE_OVERHEAT;
        end else if (item_i.start_pressed) begin
          mode_d = MODE_ROLLING;
        end
      end
      MODE_ROLLING: begin
        feed_d   = 1'b1;
        cut_en_d = 1'b0;
        dir_d    = 1'b0;
        if (hot) begin
          feed_d = 1'b0;
          mode_d = MODE_OVERHEAT;
        end else if (item_i.beam_blocked) begin
          mode_d = MODE_PAUSE;
          tick_d = '0;
        end
      end
      MODE_PAUSE: begin
        feed_d   = 1'b0;
        cut_en_d = 1'b0;
        dir_d    = 1'b0;
        tick_d   = tick_inc;
        if (tick_inc_ext >= pause_lim) begin
          tick_d     = '0;
          upstroke_d = 1'b0;
          mode_d     = MODE_CUTTING;
        end
      end
      MODE_CUTTING: begin
        feed_d   = 1'b0;
        cut_en_d = 1'b1;
        dir_d    = upstroke_q;
        tick_d   = tick_inc;
        if (tick_inc_ext >= cut_lim) begin
          tick_d = '0;
          if (upstroke_q) begin
            upstroke_d = 1'b0;
            mode_d     = MODE_ROLLING;
          end else begin
            upstroke_d = 1'b1;
          end
        end
      end
      MODE_OVERHEAT: begin
        heater_d   = 1'b0;
        feed_d     = 1'b0;
        cut_en_d   = 1'b0;
        dir_d      = 1'b0;
        upstroke_d = 1'b0;
        tick_d     = '0;
        if (temp_s < resume_s) begin
          mode_d = MODE_HEATING;
        end
      end
      default: begin
        mode_d   = MODE_HEATING;
        heater_d = 1'b1;
        if (hot) begin
          mode_d = MODE_OVERHEAT;
        end else if (temp_s >= tgt_s) begin
          mode_d = MODE_READY;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_HEATING;
      heater_q   <= 1'b0;
      feed_q     <= 1'b0;
      cut_en_q   <= 1'b0;
      dir_q      <= 1'b0;
      upstroke_q <= 1'b0;
      tick_q     <= '0;
    end else if (step_i) begin
      mode_q     <= mode_d;
      heater_q   <= heater_d;
      feed_q     <= feed_d;
      cut_en_q   <= cut_en_d;
      dir_q      <= dir_d;
      upstroke_q <= upstroke_d;
      tick_q     <= tick_d;
    end
  end

  always_comb begin
    res_o.mode_code      = mode_d;
    res_o.heater_on      = heater_d;
    res_o.feed_run       = feed_d;
    res_o.feed_speed     = feed_d ? cfg_i.feed_speed_set : '0;
    res_o.cutter_run     = cut_en_d;
    res_o.cutter_reverse = cut_en_d & dir_d;
    res_o.cutter_speed   = cut_en_d ? cfg_i.cutter_speed_set : '0;
  end

endmodule

// ===== src/heater_and_cutter_sequencer.sv =====
// Top level of the heater and cutter sequencer: item pipeline and ports.
//
// Each input item is one control tick: a temperature sample in tenths of a
// degree, the start button level and the beam-breaker level. Each item gives
// exactly one result item with the mode code and the heater, feed and cutter
// drives that hold after the tick.
// An accepted item sits in the input register while the next state is worked
// out; once the output register is free, the state machine advances and the
// result is written to the output register, from which it is offered. One
// item is taken per cycle while the receiver does not stall; the rate is set
// by the single state update per item.
// When the receiver stalls, the result register holds its item and the input
// register holds the next one; input ready drops only when both are full.
// Configuration writes are taken in every cycle and must be made while no item
// is in flight.
// Reset clears the valid flags of both registers, puts the block in heating
// with all drives off and loads the default configuration values.
module heater_and_cutter_sequencer #(
  parameter int COUNT_WIDTH = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  hcs_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output hcs_pkg::out_t                   out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hcs_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [hcs_pkg::LevelWidth-1:0]  cfg_data_i
);
  import hcs_pkg::*;

  logic  in_valid_q;
  in_t   in_data_q;
  logic  out_valid_q;
  out_t  out_data_q;
  logic  step;
  logic  out_free;
  cfg_t  cfg;
  out_t  res;

  assign out_free    = !out_valid_q || out_ready_i;
  assign step        = in_valid_q && out_free;
  assign in_ready_o  = !in_valid_q || out_free;
  assign cfg_ready_o = 1'b1;

  hcs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  hcs_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
    if (step) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_feed_speed_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.feed_run |-> out_data_o.feed_speed == '0)
    else $error("feed speed nonzero while feed is stopped");

  a_cutter_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.cutter_run |->
      !out_data_o.cutter_reverse && out_data_o.cutter_speed == '0)
    else $error("cutter drive active while cutter is stopped");

  a_no_feed_and_cut : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.feed_run && out_data_o.cutter_run))
    else $error("feed and cutter run together");

  a_item_advances : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_valid_q |=> out_valid_o)
    else $error("held item did not reach the output register");

endmodule
